### design/ntm_pkg.sv
// ntm_pkg: shared types, codes and defaults of the nearest timestamp matcher
// used by the core, the top level and the checker; no dependencies
package ntm_pkg;

	// field widths fixed by the command and result formats
	localparam int FUNC_W   = 2;
	localparam int STAMP_W  = 40;
	localparam int STATUS_W = 3;
	localparam int QIDX_W   = 16;
	localparam int RIDX_W   = 10;
	localparam int GAP_W    = 40;

	// parameter defaults
	localparam int REF_DEPTH_DEF = 1024;
	localparam int TIME_BITS_DEF = 40;

	// configuration port
	localparam int APB_DATA_W = 64;
	localparam int APB_ADDR_W = 3;
	localparam logic [APB_ADDR_W-1:0] ADDR_MAX_GAP = 3'd0;
	localparam logic [GAP_W-1:0] MAX_GAP_RST = 40'd20000;

	// command codes
	localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_QUERY   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;
	// unused code, taken and dropped with no result
	localparam logic [FUNC_W-1:0] FUNC_NONE    = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_LOADED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_RESTART = 3'd2;
	localparam logic [STATUS_W-1:0] ST_MATCHED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOMATCH = 3'd4;

	typedef struct packed {
		logic [FUNC_W-1:0]  func;
		logic [STAMP_W-1:0] stamp;
	} ntm_cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [QIDX_W-1:0]   query_index;
		logic [RIDX_W-1:0]   ref_index;
		logic [GAP_W-1:0]    gap;
	} ntm_res_t;

endpackage

### design/ntm_core.sv
// ntm_core: reference store, scan sequencer and match decision
// depends on ntm_pkg
module ntm_core #(
	parameter int REF_DEPTH = ntm_pkg::REF_DEPTH_DEF,
	parameter int TIME_BITS = ntm_pkg::TIME_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  ntm_pkg::ntm_cmd_t       cmd,
	input  logic [ntm_pkg::GAP_W-1:0] max_gap,
	output logic                    busy,
	output logic                    done,
	output ntm_pkg::ntm_res_t       result
);
	import ntm_pkg::*;

	localparam int AW = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
	localparam int CW = $clog2(REF_DEPTH + 1);
	localparam int TW = TIME_BITS;
	localparam int MW = (TW > GAP_W) ? TW : GAP_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EVAL = 2'd1;
	localparam logic [1:0] S_PICK = 2'd2;

	function automatic logic [TW-1:0] abs_diff(input logic [TW-1:0] a, input logic [TW-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	logic [1:0]        state_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     scan_q;
	logic              used_at_q;
	logic              used_bef_q;
	logic [QIDX_W-1:0] qcount_q;
	logic [QIDX_W-1:0] qidx_q;
	logic [TW-1:0]     t_q;
	logic [TW-1:0]     prev_q;
	logic [TW-1:0]     rd_q;
	logic [TW-1:0]     gcur_q;
	logic [TW-1:0]     gprev_q;
	logic              cur_ok_q;
	logic              prev_ok_q;
	logic              done_q;
	ntm_res_t          res_q;

	logic [TW-1:0] ref_mem [REF_DEPTH];

	logic          accept;
	logic [TW-1:0] t_in;
	logic          full;
	logic          mem_we;
	logic          mem_re;
	logic [AW-1:0] mem_ra;
	logic          advance;
	logic          pick_prev;
	logic          cur_in;
	logic          prev_in;
	logic          match;
	logic [TW-1:0] gap_sel;
	logic [AW-1:0] ridx_sel;

	assign accept  = start && (state_q == S_IDLE);
	assign t_in    = TW'(cmd.stamp);
	assign full    = (count_q == CW'(REF_DEPTH));
	assign mem_we  = accept && (cmd.func == FUNC_LOAD) && !full;

	// scan moves on while a later entry exists and this one is earlier than the query
	assign advance = ((CW'(scan_q) + CW'(1)) < count_q) && (rd_q < t_q);

	// read address: the scan position on query accept, the next entry on advance
	always_comb begin
		mem_re = 1'b0;
		mem_ra = scan_q;
		if (accept && (cmd.func == FUNC_QUERY)) begin
			mem_re = 1'b1;
		end else if ((state_q == S_EVAL) && advance) begin
			mem_re = 1'b1;
			mem_ra = scan_q + AW'(1);
		end
	end

	// reference store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ref_mem[count_q[AW-1:0]] <= t_in;
		end
		if (mem_re) begin
			rd_q <= ref_mem[mem_ra];
		end
	end

	// match decision over the two candidates, later entry wins a tie
	assign cur_in    = MW'(gcur_q) <= MW'(max_gap);
	assign prev_in   = MW'(gprev_q) <= MW'(max_gap);
	assign pick_prev = prev_ok_q && (!cur_ok_q || (gprev_q < gcur_q));
	assign gap_sel   = pick_prev ? gprev_q : gcur_q;
	assign ridx_sel  = pick_prev ? (scan_q - AW'(1)) : scan_q;
	assign match     = (cur_ok_q || prev_ok_q) && (pick_prev ? prev_in : cur_in);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			scan_q     <= '0;
			used_at_q  <= 1'b0;
			used_bef_q <= 1'b0;
			qcount_q   <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd.func)
							FUNC_LOAD: begin
								done_q <= 1'b1;
								if (!full) begin
									count_q <= count_q + CW'(1);
								end
							end
							FUNC_RESTART: begin
								done_q     <= 1'b1;
								count_q    <= '0;
								scan_q     <= '0;
								used_at_q  <= 1'b0;
								used_bef_q <= 1'b0;
								qcount_q   <= '0;
							end
							FUNC_QUERY: begin
								state_q <= S_EVAL;
								if (qcount_q != '1) begin
									qcount_q <= qcount_q + QIDX_W'(1);
								end
							end
							default: ;
						endcase
					end
				end
				S_EVAL: begin
					if (advance) begin
						scan_q     <= scan_q + AW'(1);
						used_bef_q <= used_at_q;
						used_at_q  <= 1'b0;
					end else begin
						state_q <= S_PICK;
					end
				end
				S_PICK: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					if (match) begin
						if (pick_prev) begin
							used_bef_q <= 1'b1;
						end else begin
							used_at_q <= 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			t_q    <= t_in;
			qidx_q <= qcount_q;
			res_q  <= '0;
			case (cmd.func)
				FUNC_LOAD:    res_q.status <= full ? ST_DROPPED : ST_LOADED;
				FUNC_RESTART: res_q.status <= ST_RESTART;
				default: ;
			endcase
		end
		if (state_q == S_EVAL) begin
			if (advance) begin
				prev_q <= rd_q;
			end else begin
				gcur_q    <= abs_diff(rd_q, t_q);
				gprev_q   <= abs_diff(prev_q, t_q);
				cur_ok_q  <= (count_q != '0) && !used_at_q;
				prev_ok_q <= (scan_q != '0) && !used_bef_q;
			end
		end
		if (state_q == S_PICK) begin
			res_q.query_index <= qidx_q;
			if (match) begin
				res_q.status    <= ST_MATCHED;
				res_q.ref_index <= RIDX_W'(ridx_sel);
				res_q.gap       <= GAP_W'(gap_sel);
			end else begin
				res_q.status    <= ST_NOMATCH;
				res_q.ref_index <= '0;
				res_q.gap       <= '0;
			end
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule

### design/nearest_timestamp_matcher.sv
// nearest_timestamp_matcher: top level with the configuration register file
// depends on ntm_pkg and ntm_core
//
// Usage:
//  - command channel: a transaction is taken at a rising edge with start high and
//    busy low; cmd.func selects load (0), query (1) or restart (2); code 3 is
//    taken and ignored with no result
//  - result channel: every load, restart and query gives one result, shown for
//    exactly one cycle with done high; the receiver cannot stall it
//  - load and restart: busy stays low, result in the cycle after the transaction,
//    one transaction per cycle
//  - query: busy after the transaction through the scan steps, the compare and
//    the pick, with one scan step for each reference entry the scan position
//    moves past; each scan step is one read of the reference store; the result
//    appears in the cycle busy drops, when the next command may already be taken
//  - max_gap reads back at byte address 0 of the APB port and a write at any address
//    reaches it (64-bit data, low 40 bits used); write it only while the block is idle
//  - reset clears the entry count, scan state and query counter; max_gap returns
//    to 20000 us; stored timestamps are not cleared and need no clearing pass
module nearest_timestamp_matcher #(
	parameter int REF_DEPTH = ntm_pkg::REF_DEPTH_DEF,
	parameter int TIME_BITS = ntm_pkg::TIME_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  ntm_pkg::ntm_cmd_t              cmd,
	output logic                           busy,
	output logic                           done,
	output ntm_pkg::ntm_res_t              result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ntm_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [ntm_pkg::APB_DATA_W-1:0] pwdata,
	output logic [ntm_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);
	import ntm_pkg::*;

	logic [GAP_W-1:0] max_gap_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// max_gap register, the only one in the map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_gap_q <= MAX_GAP_RST;
		end else if (cfg_wr) begin
			max_gap_q <= pwdata[GAP_W-1:0];
		end
	end

	// read back
	assign prdata = (paddr == ADDR_MAX_GAP) ? APB_DATA_W'(max_gap_q) : '0;

	ntm_core #(
		.REF_DEPTH(REF_DEPTH),
		.TIME_BITS(TIME_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.max_gap(max_gap_q),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

endmodule

### design/ntm_checker.sv
// ntm_checker: port-level assertions for nearest_timestamp_matcher, with its bind
// depends on ntm_pkg
module ntm_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input ntm_pkg::ntm_cmd_t cmd,
	input logic              busy,
	input logic              done,
	input ntm_pkg::ntm_res_t result
);
	import ntm_pkg::*;

	logic take;
	assign take = start && !busy;

	// load and restart answer in the next cycle
	a_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		take && (cmd.func == FUNC_LOAD || cmd.func == FUNC_RESTART) |=> done)
		else $error("load or restart gave no result in the next cycle");

	// a query holds the command side off while it scans
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		take && cmd.func == FUNC_QUERY |=> busy && !done)
		else $error("query did not occupy the block");

	// the unused code gives no result
	a_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		take && cmd.func == FUNC_NONE |=> !done)
		else $error("unused command produced a result");

	// only a match carries an index and a gap
	a_clean_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != ST_MATCHED |-> result.ref_index == '0 && result.gap == '0)
		else $error("non-match result carries match fields");

	// non-query results carry no query number
	a_qidx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status == ST_LOADED || result.status == ST_DROPPED
			|| result.status == ST_RESTART) |-> result.query_index == '0)
		else $error("non-query result carries a query number");

endmodule

bind nearest_timestamp_matcher ntm_checker u_ntm_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.cmd   (cmd),
	.busy  (busy),
	.done  (done),
	.result(result)
);

### dv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench for the nearest timestamp matcher
// drives commands and max_gap writes, predicts every result in order and checks it
// depends on ntm_pkg and the nearest_timestamp_matcher top level
module tb;
	import ntm_pkg::*;

	localparam int DEPTH = REF_DEPTH_DEF;
	localparam int LIMIT = 3000000;
	localparam int QIDX_SAT = 65535;
	localparam logic [STAMP_W-1:0] T_MAX = '1;

	typedef struct packed {
		logic [FUNC_W-1:0]   func;
		logic [STAMP_W-1:0]  stamp;
		logic                typed;
		logic [STATUS_W-1:0] status;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	ntm_cmd_t cmd = '0;
	logic busy;
	logic done;
	ntm_res_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	// shadow state of the matcher
	logic [STAMP_W-1:0] ref_store [DEPTH];
	int ref_fill = 0;
	int scan_at = 0;
	bit used_at = 1'b0;
	bit used_prev = 1'b0;
	int query_num = 0;
	logic [GAP_W-1:0] gap_limit = MAX_GAP_RST;

	ntm_res_t pending_results [$];
	int mismatches = 0;
	int results_due = 0;
	int burst_left = 0;
	int cycles = 0;

	// directed commands; status typed in where it is obvious, else predicted
	row_t dir_rows [24] = '{
		'{FUNC_QUERY,   40'd0,           1'b1, ST_NOMATCH}, // empty store after reset
		'{FUNC_NONE,    T_MAX,           1'b0, ST_LOADED},  // unused code, no result
		'{FUNC_RESTART, T_MAX,           1'b1, ST_RESTART},
		'{FUNC_QUERY,   40'd5,           1'b1, ST_NOMATCH}, // still empty
		'{FUNC_RESTART, 40'd0,           1'b1, ST_RESTART},
		'{FUNC_LOAD,    40'd0,           1'b1, ST_LOADED},
		'{FUNC_LOAD,    40'd1000,        1'b1, ST_LOADED},
		'{FUNC_LOAD,    40'd1000,        1'b1, ST_LOADED},  // equal stamps
		'{FUNC_LOAD,    40'd25000,       1'b1, ST_LOADED},
		'{FUNC_LOAD,    T_MAX,           1'b1, ST_LOADED},
		'{FUNC_QUERY,   40'd0,           1'b0, ST_LOADED},
		'{FUNC_QUERY,   40'd0,           1'b0, ST_LOADED},  // entry already used
		'{FUNC_QUERY,   40'd1000,        1'b0, ST_LOADED},  // advance by one
		'{FUNC_QUERY,   40'd1000,        1'b0, ST_LOADED},
		'{FUNC_QUERY,   40'd1000,        1'b0, ST_LOADED},  // both candidates used
		'{FUNC_QUERY,   40'd13000,       1'b0, ST_LOADED},  // equal gaps
		'{FUNC_QUERY,   40'd45001,       1'b0, ST_LOADED},  // beyond max_gap
		'{FUNC_QUERY,   T_MAX,           1'b0, ST_LOADED},  // no advance, scan already at the last entry
		'{FUNC_QUERY,   T_MAX,           1'b0, ST_LOADED},
		'{FUNC_RESTART, 40'd0,           1'b1, ST_RESTART},
		'{FUNC_LOAD,    40'h5555555555,  1'b1, ST_LOADED},
		'{FUNC_LOAD,    40'h2AAAAAAAAA,  1'b1, ST_LOADED},  // unsorted pair
		'{FUNC_QUERY,   40'hAAAAAAAAAA,  1'b0, ST_LOADED},
		'{FUNC_QUERY,   40'h5555555555,  1'b0, ST_LOADED}
	};

	nearest_timestamp_matcher u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.cmd     (cmd),
		.busy    (busy),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic logic [STAMP_W-1:0] rand_stamp();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[STAMP_W-1:0];
	endfunction

	// predicts one command against the shadow state; returns 0 when no result follows
	function automatic bit predict_match(input ntm_cmd_t c, output ntm_res_t r);
		int j;
		int best;
		bit have;
		logic [STAMP_W-1:0] t;
		logic [STAMP_W-1:0] d;
		logic [STAMP_W-1:0] best_gap;
		r = '0;
		t = c.stamp;
		case (c.func)
			FUNC_LOAD: begin
				if (ref_fill >= DEPTH) begin
					r.status = ST_DROPPED;
				end else begin
					ref_store[ref_fill] = t;
					ref_fill++;
					r.status = ST_LOADED;
				end
			end
			FUNC_RESTART: begin
				ref_fill = 0;
				scan_at = 0;
				used_at = 1'b0;
				used_prev = 1'b0;
				query_num = 0;
				r.status = ST_RESTART;
			end
			FUNC_QUERY: begin
				r.query_index = QIDX_W'(query_num);
				if (query_num < QIDX_SAT)
					query_num++;
				// scan forward past earlier entries
				j = scan_at;
				while (j + 1 < ref_fill && j < DEPTH - 1 && ref_store[j] < t) begin
					j++;
					used_prev = used_at;
					used_at = 1'b0;
				end
				scan_at = j;
				have = 1'b0;
				best = 0;
				best_gap = '0;
				if (j < ref_fill && !used_at) begin
					have = 1'b1;
					best = j;
					best_gap = (ref_store[j] > t) ? ref_store[j] - t : t - ref_store[j];
				end
				// earlier entry wins only on a strictly smaller gap
				if (j >= 1 && j - 1 < ref_fill && !used_prev) begin
					d = (ref_store[j-1] > t) ? ref_store[j-1] - t : t - ref_store[j-1];
					if (!have || d < best_gap) begin
						have = 1'b1;
						best = j - 1;
						best_gap = d;
					end
				end
				if (have && best_gap <= gap_limit) begin
					if (best == j)
						used_at = 1'b1;
					else
						used_prev = 1'b1;
					r.status = ST_MATCHED;
					r.ref_index = RIDX_W'(best);
					r.gap = best_gap;
				end else begin
					r.status = ST_NOMATCH;
				end
			end
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	task automatic flag(input string what, input logic [63:0] want, input logic [63:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected %0h, got %0h", what, want, got);
	endtask

	// result checker, oldest expectation first
	always @(posedge clk) begin : check_results
		ntm_res_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				flag("unexpected result status", '0, 64'(result.status));
			end else begin
				want = pending_results.pop_front();
				if (result.status !== want.status)
					flag("status", 64'(want.status), 64'(result.status));
				if (result.query_index !== want.query_index)
					flag("query_index", 64'(want.query_index), 64'(result.query_index));
				if (result.ref_index !== want.ref_index)
					flag("ref_index", 64'(want.ref_index), 64'(result.ref_index));
				if (result.gap !== want.gap)
					flag("gap", 64'(want.gap), 64'(result.gap));
			end
		end
	end

	// one command transaction; sender works in bursts with random gaps
	task automatic issue(input logic [FUNC_W-1:0] f, input logic [STAMP_W-1:0] s,
			input bit typed = 1'b0, input logic [STATUS_W-1:0] typed_status = ST_LOADED);
		ntm_cmd_t c;
		ntm_res_t r;
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120)
				: $urandom_range(1, 12);
		end
		burst_left--;
		c.func = f;
		c.stamp = s;
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		if (predict_match(c, r)) begin
			results_due++;
			if (typed)
				r = '{status: typed_status, query_index: '0, ref_index: '0, gap: '0};
			pending_results = {pending_results, r};
		end
	endtask

	// drain, then write max_gap and read it back
	task automatic set_max_gap(input logic [GAP_W-1:0] v);
		logic [APB_DATA_W-GAP_W-1:0] junk;
		junk = (APB_DATA_W-GAP_W)'($urandom);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_MAX_GAP;
		pwdata <= {junk, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		gap_limit = v;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[GAP_W-1:0] !== v)
			flag("max_gap readback", 64'(v), 64'(prdata[GAP_W-1:0]));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// restart, mostly ascending references, then mostly queries walking along them, with some extra loads and noise
	task automatic run_sequence();
		logic [STAMP_W-1:0] seq_times [$];
		logic [STAMP_W-1:0] t;
		logic [STAMP_W-1:0] q;
		logic [STAMP_W:0] mid;
		int n;
		int k;
		int jit;
		jit = (gap_limit > 40000) ? 40000 : int'(gap_limit) * 2 + 3;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 16);
		issue(FUNC_RESTART, rand_stamp());
		t = rand_stamp();
		repeat (n) begin
			if ($urandom_range(0, 19) == 0)
				t = t - $urandom_range(0, 5000);
			else
				t = t + $urandom_range(0, 30000);
			issue(FUNC_LOAD, t);
			seq_times = {seq_times, t};
		end
		k = 0;
		repeat ($urandom_range(1, n + 4)) begin
			case ($urandom_range(0, 19))
				0: issue(FUNC_NONE, rand_stamp());
				1: issue(FUNC_QUERY, rand_stamp());
				2: begin
					t = seq_times[seq_times.size()-1] + $urandom_range(0, 30000);
					issue(FUNC_LOAD, t);
					seq_times = {seq_times, t};
				end
				default: begin
					k += $urandom_range(0, 2);
					if (k >= seq_times.size())
						k = seq_times.size() - 1;
					q = seq_times[k];
					case ($urandom_range(0, 3))
						0: q = q;
						1: q = q + $urandom_range(0, jit);
						2: q = q - $urandom_range(0, jit);
						default: begin
							// midpoint gives equal gaps on even spacing
							if (k + 1 < seq_times.size()) begin
								mid = ({1'b0, seq_times[k]} + {1'b0, seq_times[k+1]}) >> 1;
								q = mid[STAMP_W-1:0];
							end
						end
					endcase
					issue(FUNC_QUERY, q);
				end
			endcase
		end
	endtask

	task automatic run_random(input int quota);
		int goal;
		goal = results_due + quota;
		while (results_due < goal) begin
			if ($urandom_range(0, 99) < 85) begin
				run_sequence();
			end else begin
				// noise: any code, any stamp
				repeat (10) issue(FUNC_W'($urandom_range(0, 3)), rand_stamp());
			end
		end
	endtask

	initial begin
		// reset
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at the reset value of max_gap
		foreach (dir_rows[i])
			issue(dir_rows[i].func, dir_rows[i].stamp, dir_rows[i].typed, dir_rows[i].status);

		// random phases across max_gap settings
		set_max_gap('0);
		run_random(150);
		set_max_gap(T_MAX);
		run_random(150);
		set_max_gap(GAP_W'($urandom_range(0, 5000)));
		run_random(150);
		set_max_gap(rand_stamp());
		run_random(150);
		set_max_gap(MAX_GAP_RST);
		run_random(150);

		// drain
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

### filelist.f
design/ntm_pkg.sv
design/ntm_core.sv
design/nearest_timestamp_matcher.sv
design/ntm_checker.sv
dv/tb.sv
